### rtl/core/mgss_pkg.sv
// Shared types, widths and helpers for the modular geometric series sum block.
// No dependencies; every other file refers to this package by scoped names.
package mgss_pkg;

    localparam int MOD_W  = 31;
    localparam int BASE_W = 32;
    localparam int TERM_W = 63;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [MOD_W-1:0]  MOD_RESET    = 31'd1000000007;
    localparam logic [ADDR_W-1:0] ADDR_MODULUS = 3'd0;

    typedef struct packed {
        logic              start;
        logic [BASE_W-1:0] x;
        logic [MOD_W-1:0]  y;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] result;
    } mul_rsp_t;

    // Sum of two residues below m, reduced once.
    function automatic logic [MOD_W-1:0] addmod(input logic [MOD_W-1:0] x,
                                                input logic [MOD_W-1:0] y,
                                                input logic [MOD_W-1:0] m);
        logic [MOD_W:0] s;
        logic [MOD_W:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, m};
        return (s >= {1'b0, m}) ? d[MOD_W-1:0] : s[MOD_W-1:0];
    endfunction

endpackage

### rtl/core/mgss_if.sv
// Handshake channel interfaces for the input and result items.
// Depends on mgss_pkg for the field widths.
interface mgss_in_if;
    logic                          valid;
    logic                          ready;
    logic [mgss_pkg::BASE_W-1:0]   base_value;
    logic [mgss_pkg::TERM_W-1:0]   term_count;

    modport source (output valid, output base_value, output term_count, input ready);
    modport sink   (input valid, input base_value, input term_count, output ready);
endinterface

interface mgss_out_if;
    logic                         valid;
    logic                         ready;
    logic [mgss_pkg::MOD_W-1:0]   series_sum;

    modport source (output valid, output series_sum, input ready);
    modport sink   (input valid, input series_sum, output ready);
endinterface

### rtl/core/mgss_mulmod.sv
// Bit-serial modular multiplier: x * y mod m, one bit of x per cycle, MSB first.
// Depends on mgss_pkg for the request and response structs.
module mgss_mulmod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mgss_pkg::mul_req_t          req,
    input  logic [mgss_pkg::MOD_W-1:0]  modulus,
    output mgss_pkg::mul_rsp_t          rsp
);
    localparam int MW    = mgss_pkg::MOD_W;
    localparam int XW    = mgss_pkg::BASE_W;
    localparam int CNT_W = $clog2(XW + 1);

    logic [XW-1:0]    x_reg;
    logic [MW-1:0]    y_reg;
    logic [MW-1:0]    r_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [MW:0]   dbl;
    logic [MW:0]   dbl_red;
    logic [MW:0]   acc;
    logic [MW:0]   acc_red;
    logic [MW-1:0] r_next;

    // r stays below m, so 2r and 2r + y each need one conditional subtract.
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
        acc     = {1'b0, dbl_red[MW-1:0]} + (x_reg[XW-1] ? {1'b0, y_reg} : '0);
        acc_red = (acc >= {1'b0, modulus}) ? acc - {1'b0, modulus} : acc;
        r_next  = acc_red[MW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(XW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= req.x;
            y_reg <= req.y;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[XW-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = r_reg;

endmodule

### rtl/core/modular_geometric_series_sum_top.sv
// Modular geometric series sum: series_sum = (1 + a + ... + a^(n-1)) mod modulus.
// Depends on mgss_pkg, mgss_if and mgss_mulmod.
// One item is worked at a time by a single bit-serial multiplier. The base is
// first reduced with one product, leading zero bits of the count are skipped
// one at a time in the scan state, and every bit after the leading one costs
// two products plus a third when the bit is set.
// A modulus below 2 returns 0 at once.
// The modulus register sits at byte address 0; write it only while idle.
module modular_geometric_series_sum_top #(
    parameter int COUNT_BITS = 63
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mgss_pkg::ADDR_W-1:0]   paddr,
    input  logic [mgss_pkg::DATA_W-1:0]   pwdata,
    output logic [mgss_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    mgss_in_if.sink                       in_ch,
    mgss_out_if.source                    out_ch
);
    localparam int MW    = mgss_pkg::MOD_W;
    localparam int IDX_W = $clog2(COUNT_BITS);

    typedef enum logic [2:0] {
        S_IDLE, S_REDUCE, S_SCAN, S_MUL_PS, S_MUL_PP, S_MUL_PA, S_FINISH
    } state_t;

    state_t                       state_reg;
    logic [MW-1:0]                modulus_reg;
    logic [mgss_pkg::BASE_W-1:0]  base_reg;
    logic [COUNT_BITS-1:0]        n_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [MW-1:0]                a_reg;
    logic [MW-1:0]                sum_reg;
    logic [MW-1:0]                pw_reg;
    logic                         wait_reg;
    logic                         out_valid_reg;
    logic [MW-1:0]                out_sum_reg;

    mgss_pkg::mul_req_t mul_req;
    mgss_pkg::mul_rsp_t mul_rsp;
    logic               in_fire;
    logic               cur_bit;
    logic               last_bit;

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= mgss_pkg::MOD_RESET;
        end
        else if (psel && penable && pwrite && (paddr == mgss_pkg::ADDR_MODULUS))
        begin
            modulus_reg <= pwdata[MW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == mgss_pkg::ADDR_MODULUS) ?
                    {{(mgss_pkg::DATA_W-MW){1'b0}}, modulus_reg} : '0;

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign in_fire           = in_ch.valid && in_ch.ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.series_sum = out_sum_reg;
    assign cur_bit           = n_reg[idx_reg];
    assign last_bit          = (idx_reg == '0);

    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.x     = {1'b0, pw_reg};
        mul_req.y     = pw_reg;
        case (state_reg)
            S_REDUCE:
            begin
                mul_req.start = !wait_reg;
                mul_req.x     = base_reg;
                mul_req.y     = MW'(1);
            end
            S_MUL_PS:
            begin
                mul_req.start = !wait_reg;
                mul_req.y     = sum_reg;
            end
            S_MUL_PP:
            begin
                mul_req.start = !wait_reg;
            end
            S_MUL_PA:
            begin
                mul_req.start = !wait_reg;
                mul_req.y     = a_reg;
            end
            default:
            begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    mgss_mulmod u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .modulus (modulus_reg),
        .rsp     (mul_rsp)
    );

    // Walk the count from its leading one down; leading zeros leave S = 0, P = 1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            if (mul_req.start)
            begin
                wait_reg <= 1'b1;
            end
            else if (mul_rsp.done)
            begin
                wait_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        base_reg  <= in_ch.base_value;
                        n_reg     <= in_ch.term_count[COUNT_BITS-1:0];
                        idx_reg   <= IDX_W'(COUNT_BITS - 1);
                        sum_reg   <= '0;
                        pw_reg    <= MW'(1);
                        state_reg <= (modulus_reg < MW'(2)) ? S_FINISH : S_REDUCE;
                    end
                end
                S_REDUCE:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        a_reg     <= mul_rsp.result;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (cur_bit)
                    begin
                        sum_reg <= MW'(1);
                        pw_reg  <= a_reg;
                    end
                    if (last_bit)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - 1'b1;
                        if (cur_bit)
                        begin
                            state_reg <= S_MUL_PS;
                        end
                    end
                end
                S_MUL_PS:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        sum_reg   <= mgss_pkg::addmod(sum_reg, mul_rsp.result, modulus_reg);
                        state_reg <= S_MUL_PP;
                    end
                end
                S_MUL_PP:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        pw_reg <= mul_rsp.result;
                        if (cur_bit)
                        begin
                            sum_reg   <= mgss_pkg::addmod(sum_reg, mul_rsp.result,
                                                          modulus_reg);
                            state_reg <= S_MUL_PA;
                        end
                        else if (last_bit)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= S_MUL_PS;
                        end
                    end
                end
                S_MUL_PA:
                begin
                    if (wait_reg && mul_rsp.done)
                    begin
                        pw_reg <= mul_rsp.result;
                        if (last_bit)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - 1'b1;
                            state_reg <= S_MUL_PS;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sum_reg   <= sum_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/mgss_checker.sv
// Port-level checks for the modular geometric series sum block, and its bind.
// Depends on mgss_pkg for widths; attaches to modular_geometric_series_sum_top.
module mgss_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [mgss_pkg::MOD_W-1:0]  series_sum,
    input logic                        pready
);
    // A stalled result item stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(series_sum))
        else $error("result changed while stalled");

    // Only one item is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    // The configuration port never inserts wait states.
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind modular_geometric_series_sum_top mgss_checker u_mgss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .series_sum (out_ch.series_sum),
    .pready     (pready)
);
